FILE: src/csvd_pkg.sv
package csvd_pkg;

    localparam int NUM_CAND            = 4;
    localparam int CAND_IDX_W          = 2;
    localparam int CHAR_W              = 8;
    localparam int TALLY_W             = 10;
    localparam int LINES_W             = 10;
    localparam int SCORE_W             = 22;
    localparam int DEF_MAX_LINE_COUNT  = 4095;

    localparam logic [TALLY_W-1:0] TALLY_MAX    = {TALLY_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_MAX    = {SCORE_W{1'b1}};
    localparam logic [LINES_W-1:0] SAMPLE_RESET = LINES_W'(100);

    typedef enum logic [1:0] {
        OP_CHAR   = 2'd0,
        OP_EOL    = 2'd1,
        OP_FINISH = 2'd2
    } t_opcode;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [CHAR_W-1:0] char_code;
    } t_in_beat;

    typedef struct packed {
        logic [CHAR_W-1:0]     delimiter_char;
        logic [CAND_IDX_W-1:0] delimiter_index;
        logic [SCORE_W-1:0]    best_score;
        logic [LINES_W-1:0]    lines_used;
    } t_out_beat;

    function automatic logic [CHAR_W-1:0] cand_char(input logic [CAND_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        unique case (idx)
            2'd0:    c = 8'd44;
            2'd1:    c = 8'd9;
            2'd2:    c = 8'd59;
            default: c = 8'd124;
        endcase
        return c;
    endfunction

endpackage

FILE: src/csvd_score.sv
module csvd_score
    import csvd_pkg::*;
#(
    parameter int CW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [TALLY_W-1:0]   i_tally [NUM_CAND],
    input  logic [CW-1:0]        i_expected [NUM_CAND],
    input  logic [LINES_W-1:0]   i_lines,
    output logic                 o_ready,
    output logic                 o_out_valid,
    output t_out_beat            o_out_data,
    input  logic                 i_out_stall
);

    localparam int PW = TALLY_W + CW;
    localparam int XW = (PW > SCORE_W) ? PW : SCORE_W;

    logic                 r_s2_v;
    logic [SCORE_W-1:0]   r_score [NUM_CAND];
    logic [LINES_W-1:0]   r_lines;
    logic                 r_out_v;
    t_out_beat            r_out;

    logic                 out_free;
    logic                 s2_free;
    logic [SCORE_W-1:0]   n_score [NUM_CAND];
    t_out_beat            n_out;
    logic [PW-1:0]        prod [NUM_CAND];
    logic [XW-1:0]        prod_x [NUM_CAND];
    logic [SCORE_W-1:0]   best;
    logic [CAND_IDX_W-1:0] best_idx;

    assign out_free = !r_out_v || !i_out_stall;
    assign s2_free  = !r_s2_v || out_free;
    assign o_ready  = s2_free;

    always_comb begin
        for (int k = 0; k < NUM_CAND; k++) begin
            prod[k]    = PW'(i_tally[k]) * PW'(i_expected[k]);
            prod_x[k]  = XW'(prod[k]);
            n_score[k] = (prod_x[k] > XW'(SCORE_MAX)) ? SCORE_MAX : prod_x[k][SCORE_W-1:0];
        end
    end

    always_comb begin
        best     = '0;
        best_idx = '0;
        for (int k = 0; k < NUM_CAND; k++) begin
            if (r_score[k] > best) begin
                best     = r_score[k];
                best_idx = CAND_IDX_W'(k);
            end
        end
        n_out.delimiter_char  = cand_char(best_idx);
        n_out.delimiter_index = best_idx;
        n_out.best_score      = best;
        n_out.lines_used      = r_lines;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_v <= i_valid;
            end
            if (out_free) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_valid) begin
            r_score <= n_score;
            r_lines <= i_lines;
        end
        if (out_free && r_s2_v) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

FILE: src/csv_delimiter_detector_unit.sv
// Delimiter detector for a character stream.
// The input channel (i_in_valid, o_in_stall, i_in_data) carries one beat per
// character, end-of-line mark or finish mark. Characters and line ends update
// the per-line counters, first-line counts and consistency tallies in the
// cycle they are accepted; one beat can be taken every cycle unless stalled.
// A finish beat closes any open line, snapshots the tallies and clears the
// sampling state at once, so the next text can follow in the very next cycle.
// The result beat appears on (o_out_valid, i_out_stall, o_out_data) after
// the accepted finish beat passes the snapshot, multiplier and selection
// registers in turn. Only finish beats produce results.
// The sample line limit is written through (i_cfg_valid, o_cfg_ready,
// i_cfg_data); the port is always ready and should be written while idle.
// Synchronous reset clears all counters and the result pipeline and sets the
// sample limit to 100 lines. When the receiver stalls, the result holds and
// the pipeline fills; o_in_stall rises only once the snapshot register is
// occupied and cannot move forward.
module csv_delimiter_detector_unit
    import csvd_pkg::*;
#(
    parameter int MAX_LINE_COUNT = DEF_MAX_LINE_COUNT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LINES_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_LINE_COUNT + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LINE_COUNT);

    logic [LINES_W-1:0] r_sample_lines;
    logic [CW-1:0]      r_lc [NUM_CAND];
    logic [CW-1:0]      r_exp [NUM_CAND];
    logic [TALLY_W-1:0] r_tally [NUM_CAND];
    logic [LINES_W-1:0] r_lines_seen;
    logic               r_open;
    logic               r_fin_v;
    logic [CW-1:0]      r_fin_exp [NUM_CAND];
    logic [TALLY_W-1:0] r_fin_tally [NUM_CAND];
    logic [LINES_W-1:0] r_fin_lines;

    logic [CW-1:0]      n_lc [NUM_CAND];
    logic [CW-1:0]      n_exp [NUM_CAND];
    logic [TALLY_W-1:0] n_tally [NUM_CAND];
    logic [LINES_W-1:0] n_lines_seen;
    logic               n_open;
    logic [CW-1:0]      n_fin_exp [NUM_CAND];
    logic [TALLY_W-1:0] n_fin_tally [NUM_CAND];
    logic [LINES_W-1:0] n_fin_lines;

    logic [CW-1:0]      cl_exp [NUM_CAND];
    logic [TALLY_W-1:0] cl_tally [NUM_CAND];
    logic [LINES_W-1:0] cl_lines;
    logic               sampling;
    logic               in_acc;
    logic               fin_take;
    logic               fin_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_fin_v && !fin_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign sampling    = r_lines_seen < r_sample_lines;

    always_comb begin
        for (int k = 0; k < NUM_CAND; k++) begin
            cl_exp[k]   = r_exp[k];
            cl_tally[k] = r_tally[k];
            if (sampling) begin
                if (r_lines_seen == '0) begin
                    cl_exp[k] = r_lc[k];
                end
                if (cl_exp[k] != '0 && r_lc[k] == cl_exp[k] && r_tally[k] < TALLY_MAX) begin
                    cl_tally[k] = r_tally[k] + TALLY_W'(1);
                end
            end
        end
        cl_lines = sampling ? r_lines_seen + LINES_W'(1) : r_lines_seen;
    end

    always_comb begin
        n_lc         = r_lc;
        n_exp        = r_exp;
        n_tally      = r_tally;
        n_lines_seen = r_lines_seen;
        n_open       = r_open;
        n_fin_exp    = r_exp;
        n_fin_tally  = r_tally;
        n_fin_lines  = r_lines_seen;
        fin_take     = 1'b0;
        if (in_acc) begin
            unique case (i_in_data.opcode)
                OP_CHAR: begin
                    if (sampling) begin
                        for (int k = 0; k < NUM_CAND; k++) begin
                            if (i_in_data.char_code == cand_char(CAND_IDX_W'(k))
                                && r_lc[k] < COUNT_MAX) begin
                                n_lc[k] = r_lc[k] + CW'(1);
                            end
                        end
                        n_open = 1'b1;
                    end
                end
                OP_EOL: begin
                    n_exp        = cl_exp;
                    n_tally      = cl_tally;
                    n_lines_seen = cl_lines;
                    n_open       = 1'b0;
                    for (int k = 0; k < NUM_CAND; k++) begin
                        n_lc[k] = '0;
                    end
                end
                OP_FINISH: begin
                    fin_take = 1'b1;
                    if (r_open) begin
                        n_fin_exp   = cl_exp;
                        n_fin_tally = cl_tally;
                        n_fin_lines = cl_lines;
                    end
                    for (int k = 0; k < NUM_CAND; k++) begin
                        n_lc[k]    = '0;
                        n_exp[k]   = '0;
                        n_tally[k] = '0;
                    end
                    n_lines_seen = '0;
                    n_open       = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_lines <= SAMPLE_RESET;
            r_lines_seen   <= '0;
            r_open         <= 1'b0;
            r_fin_v        <= 1'b0;
            for (int k = 0; k < NUM_CAND; k++) begin
                r_lc[k]    <= '0;
                r_exp[k]   <= '0;
                r_tally[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_sample_lines <= i_cfg_data;
            end
            r_lc         <= n_lc;
            r_exp        <= n_exp;
            r_tally      <= n_tally;
            r_lines_seen <= n_lines_seen;
            r_open       <= n_open;
            if (fin_take) begin
                r_fin_v <= 1'b1;
            end else if (fin_ready) begin
                r_fin_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_take) begin
            r_fin_exp   <= n_fin_exp;
            r_fin_tally <= n_fin_tally;
            r_fin_lines <= n_fin_lines;
        end
    end

    csvd_score #(
        .CW (CW)
    ) u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_fin_v),
        .i_tally     (r_fin_tally),
        .i_expected  (r_fin_exp),
        .i_lines     (r_fin_lines),
        .o_ready     (fin_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: src/csvd_chk.sv
module csvd_chk
    import csvd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_beat          o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result beat changed.");

    a_char_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.delimiter_char == cand_char(o_out_data.delimiter_index))
        else $error("Delimiter byte does not match its index.");

    a_zero_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.best_score == '0 |-> o_out_data.delimiter_index == '0)
        else $error("Zero score must report the comma.");

    a_no_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.lines_used == '0 |-> o_out_data.best_score == '0)
        else $error("Nonzero score with no scored lines.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result beat valid right after reset.");

endmodule

bind csv_delimiter_detector_unit csvd_chk u_chk (.*);
